### rtl/abdd_pkg.sv
`default_nettype none

package abdd_pkg;

    // default geometry of the head
    localparam int BINS_DEF      = 16;
    localparam int KEYPOINTS_DEF = 5;
    localparam int SIDES         = 4;

    // field widths
    localparam int ROW_W    = 8;
    localparam int STRIDE_W = 7;
    localparam int VAL_W    = 16;
    localparam int COORD_W  = 14;
    localparam int SIZE_W   = 13;
    localparam int SCORE_W  = 16;
    localparam int PIDX_W   = 3;
    localparam int PAD_W    = 12;
    localparam int SCALE_W  = 16;
    localparam int IMG_W    = 14;

    // configuration port
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_THRESHOLD = 3'd0,
        CFG_PAD_LEFT  = 3'd1,
        CFG_PAD_TOP   = 3'd2,
        CFG_SCALE_X   = 3'd3,
        CFG_SCALE_Y   = 3'd4,
        CFG_IMG_WIDTH = 3'd5,
        CFG_IMG_HEIGHT = 3'd6
    } cfg_addr_t;

    typedef struct packed {
        logic [SCORE_W-1:0] threshold;
        logic [PAD_W-1:0]   pad_left;
        logic [PAD_W-1:0]   pad_top;
        logic [SCALE_W-1:0] scale_x;
        logic [SCALE_W-1:0] scale_y;
        logic [IMG_W-1:0]   image_width;
        logic [IMG_W-1:0]   image_height;
    } cfg_t;

    // queue between front and back
    localparam int Q_DEPTH   = 2;
    localparam int REC_IDX_W = 5;

    typedef enum logic [1:0] {
        TAG_NONE   = 2'd0,
        TAG_CLASS  = 2'd1,
        TAG_BIN    = 2'd2,
        TAG_OFFSET = 2'd3
    } tag_t;

    typedef struct packed {
        tag_t                 tag;
        logic [REC_IDX_W-1:0] idx;
        logic [1:0]           side;
        logic                 side_last;
        logic                 cell_end;
        logic                 complete;
        logic [ROW_W-1:0]     row;
        logic [ROW_W-1:0]     col;
        logic [STRIDE_W-1:0]  stride;
        logic signed [VAL_W-1:0] value;
    } rec_t;

    // exponential unit
    localparam int EXP_T_W     = 16;
    localparam int EXP_W_W     = 17;
    localparam int LN2_RECIP   = 94548;
    localparam int TAYLOR_K    = 45426;
    localparam int DIV6_RECIP  = 683;
    localparam int DIV6_SHIFT  = 12;
    localparam int ONE_Q16     = 65536;

    // shared divider
    localparam int DIV_DVD_W = 40;
    localparam int DIV_DSR_W = 24;
    localparam int DIV_Q_W   = 17;

    // geometry
    localparam int NET_W   = 30;
    localparam int SC_W    = 48;
    localparam int DIFF_W  = 49;
    localparam int FRAC_SH = 23;

    function automatic logic [16:0] quarter_pow(input logic [1:0] fq);
        logic [16:0] r;
        case (fq)
            2'd0: r = 17'd65536;
            2'd1: r = 17'd55109;
            2'd2: r = 17'd46341;
            default: r = 17'd38968;
        endcase
        return r;
    endfunction

    // shift right by the fraction width, rounding toward zero
    function automatic logic signed [DIFF_W-FRAC_SH-1:0] trunc_q23(
        input logic signed [DIFF_W-1:0] v);
        logic signed [DIFF_W-1:0] adj;
        adj = v;
        if (v < 0)
        begin
            adj = v + DIFF_W'((64'd1 << FRAC_SH) - 64'd1);
        end
        return (DIFF_W-FRAC_SH)'(adj >>> FRAC_SH);
    endfunction

    function automatic logic [COORD_W-1:0] sat_coord(input logic signed [DIFF_W-1:0] v);
        logic signed [DIFF_W-FRAC_SH-1:0] t;
        logic [COORD_W-1:0] r;
        t = trunc_q23(v);
        if (t < -(DIFF_W-FRAC_SH)'(8192))
            r = COORD_W'(14'h2000);
        else if (t > (DIFF_W-FRAC_SH)'(8191))
            r = COORD_W'(14'h1FFF);
        else
            r = t[COORD_W-1:0];
        return r;
    endfunction

    function automatic logic [SIZE_W-1:0] sat_size(input logic signed [DIFF_W-1:0] v);
        logic signed [DIFF_W-FRAC_SH-1:0] t;
        logic [SIZE_W-1:0] r;
        t = trunc_q23(v);
        if (t < 0)
            r = '0;
        else if (t > (DIFF_W-FRAC_SH)'(8191))
            r = '1;
        else
            r = t[SIZE_W-1:0];
        return r;
    endfunction

endpackage

`default_nettype wire

### rtl/abdd_exp.sv
`default_nettype none

module abdd_exp
    import abdd_pkg::*;
#(
    parameter int TAG_W = 4
)
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               in_valid,
    input  wire logic [EXP_T_W-1:0] in_t,
    input  wire logic [TAG_W-1:0]   in_tag,
    output logic                    out_valid,
    output logic [EXP_W_W-1:0]      out_w,
    output logic [TAG_W-1:0]        out_tag
);

    localparam int STAGES = 7;

    logic [STAGES-1:0] vld_reg;
    logic [TAG_W-1:0]  tag_reg [STAGES];

    logic [6:0]  n1_reg, n2_reg, n3_reg, n4_reg, n5_reg, n6_reg;
    logic [15:0] f1_reg;
    logic [1:0]  fq2_reg, fq3_reg, fq4_reg, fq5_reg;
    logic [13:0] a2_reg, a3_reg, a4_reg;
    logic [11:0] sq3_reg, sq4_reg;
    logic [9:0]  cu4_reg;
    logic [17:0] p5_reg;
    logic [17:0] m6_reg;
    logic [EXP_W_W-1:0] w7_reg;

    logic [32:0] prod1;
    logic [22:0] u1;
    logic [29:0] ta;
    logic [27:0] tsq;
    logic [26:0] tcu;
    logic [19:0] td6;
    logic [17:0] p_c;
    logic [34:0] tm;
    logic [18:0] rnd;
    logic [EXP_W_W-1:0] w_c;

    // arithmetic of each stage
    always_comb
    begin
        prod1 = 33'(in_t) * 33'(LN2_RECIP);
        u1    = 23'((prod1 + 33'd512) >> 10);
        ta    = 30'(f1_reg[13:0]) * 30'(TAYLOR_K) + 30'd32768;
        tsq   = 28'(a2_reg) * 28'(a2_reg) + 28'd32768;
        tcu   = 27'(sq3_reg) * 27'(a3_reg) + 27'd32768;
        td6   = (20'(cu4_reg) * 20'(DIV6_RECIP)) >> DIV6_SHIFT;
        p_c   = 18'(ONE_Q16) - 18'(a4_reg) + 18'(sq4_reg >> 1) - 18'(td6);
        tm    = 35'(p5_reg) * 35'(quarter_pow(fq5_reg)) + 35'd32768;
        rnd   = '0;
        w_c   = '0;
        if (n6_reg == 7'd0)
        begin
            w_c = m6_reg[EXP_W_W-1:0];
        end
        else if (n6_reg <= 7'd16)
        begin
            rnd = 19'd1 << (n6_reg - 7'd1);
            w_c = EXP_W_W'((19'(m6_reg) + rnd) >> n6_reg);
        end
    end

    // valid chain
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            vld_reg <= {vld_reg[STAGES-2:0], in_valid};
        end
    end

    // stage registers
    always_ff @(posedge clk)
    begin
        tag_reg[0] <= in_tag;
        for (int i = 1; i < STAGES; i++)
        begin
            tag_reg[i] <= tag_reg[i-1];
        end
        n1_reg  <= u1[22:16];
        f1_reg  <= u1[15:0];
        n2_reg  <= n1_reg;
        fq2_reg <= f1_reg[15:14];
        a2_reg  <= 14'(ta >> 16);
        n3_reg  <= n2_reg;
        fq3_reg <= fq2_reg;
        a3_reg  <= a2_reg;
        sq3_reg <= 12'(tsq >> 16);
        n4_reg  <= n3_reg;
        fq4_reg <= fq3_reg;
        a4_reg  <= a3_reg;
        sq4_reg <= sq3_reg;
        cu4_reg <= 10'(tcu >> 16);
        n5_reg  <= n4_reg;
        fq5_reg <= fq4_reg;
        p5_reg  <= p_c;
        n6_reg  <= n5_reg;
        m6_reg  <= 18'(tm >> 16);
        w7_reg  <= w_c;
    end

    assign out_valid = vld_reg[STAGES-1];
    assign out_w     = w7_reg;
    assign out_tag   = tag_reg[STAGES-1];

endmodule

`default_nettype wire

### rtl/abdd_div.sv
`default_nettype none

module abdd_div
    import abdd_pkg::*;
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 start,
    input  wire logic [DIV_DVD_W-1:0] dividend,
    input  wire logic [DIV_DSR_W-1:0] divisor,
    output logic                      done,
    output logic [DIV_Q_W-1:0]        quotient
);

    localparam int CNT_W = $clog2(DIV_Q_W);

    logic                 busy_reg;
    logic                 done_reg;
    logic [CNT_W-1:0]     cnt_reg;
    logic [DIV_DSR_W-1:0] rem_reg;
    logic [DIV_DSR_W-1:0] dsr_reg;
    logic [DIV_Q_W-1:0]   lo_reg;
    logic [DIV_Q_W-1:0]   q_reg;

    logic [DIV_DSR_W:0]   trial;
    logic                 fits;

    // one quotient bit per cycle
    always_comb
    begin
        trial = {rem_reg, lo_reg[DIV_Q_W-1]};
        fits  = trial >= {1'b0, dsr_reg};
    end

    // control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + CNT_W'(1);
                if (cnt_reg == CNT_W'(DIV_Q_W - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // datapath
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= DIV_DSR_W'(dividend >> DIV_Q_W);
            lo_reg  <= dividend[DIV_Q_W-1:0];
            dsr_reg <= divisor;
        end
        else if (busy_reg)
        begin
            rem_reg <= fits ? DIV_DSR_W'(trial - {1'b0, dsr_reg}) : trial[DIV_DSR_W-1:0];
            lo_reg  <= {lo_reg[DIV_Q_W-2:0], 1'b0};
            q_reg   <= {q_reg[DIV_Q_W-2:0], fits};
        end
    end

    assign done     = done_reg;
    assign quotient = q_reg;

endmodule

`default_nettype wire

### rtl/abdd_front.sv
`default_nettype none

module abdd_front
    import abdd_pkg::*;
#(
    parameter int BINS      = BINS_DEF,
    parameter int KEYPOINTS = KEYPOINTS_DEF
)
(
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                in_valid,
    output logic                     in_stall,
    input  wire logic [ROW_W-1:0]    cell_row,
    input  wire logic [ROW_W-1:0]    cell_col,
    input  wire logic [STRIDE_W-1:0] stride,
    input  wire logic [VAL_W-1:0]    value,
    input  wire logic                cell_end,
    input  wire logic                pop,
    output logic                     head_valid,
    output rec_t                     head
);

    localparam int TOTAL = 1 + SIDES * BINS + 2 * KEYPOINTS;
    localparam int POS_W = $clog2(TOTAL + 1);
    localparam int BIN_W = $clog2(BINS);
    localparam int OFF_W = $clog2(2 * KEYPOINTS);
    localparam int PTR_W = $clog2(Q_DEPTH);
    localparam int CNT_W = $clog2(Q_DEPTH + 1);

    logic [POS_W-1:0] pos_reg;
    logic [BIN_W-1:0] bin_reg;
    logic [1:0]       side_reg;
    logic [OFF_W-1:0] off_reg;

    rec_t             mem_reg [Q_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [CNT_W-1:0] cnt_reg;

    logic accept;
    rec_t rec;

    assign in_stall   = cnt_reg == CNT_W'(Q_DEPTH);
    assign accept     = in_valid && !in_stall;
    assign head_valid = cnt_reg != '0;
    assign head       = mem_reg[rd_ptr_reg];

    // classify the request by its place in the cell
    always_comb
    begin
        rec           = '0;
        rec.row       = cell_row;
        rec.col       = cell_col;
        rec.stride    = stride;
        rec.value     = value;
        rec.cell_end  = cell_end;
        rec.tag       = TAG_NONE;
        rec.side      = side_reg;
        rec.complete  = pos_reg == POS_W'(TOTAL - 1);
        if (pos_reg == '0)
        begin
            rec.tag = TAG_CLASS;
        end
        else if (pos_reg <= POS_W'(SIDES * BINS))
        begin
            rec.tag       = TAG_BIN;
            rec.idx       = REC_IDX_W'(bin_reg);
            rec.side_last = bin_reg == BIN_W'(BINS - 1);
        end
        else if (pos_reg < POS_W'(TOTAL))
        begin
            rec.tag = TAG_OFFSET;
            rec.idx = REC_IDX_W'(off_reg);
        end
    end

    // position counters
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg  <= '0;
            bin_reg  <= '0;
            side_reg <= '0;
            off_reg  <= '0;
        end
        else if (accept)
        begin
            if (cell_end)
            begin
                pos_reg  <= '0;
                bin_reg  <= '0;
                side_reg <= '0;
                off_reg  <= '0;
            end
            else if (pos_reg < POS_W'(TOTAL))
            begin
                pos_reg <= pos_reg + POS_W'(1);
                if (rec.tag == TAG_BIN)
                begin
                    if (rec.side_last)
                    begin
                        bin_reg  <= '0;
                        side_reg <= side_reg + 2'd1;
                    end
                    else
                    begin
                        bin_reg <= bin_reg + BIN_W'(1);
                    end
                end
                if (rec.tag == TAG_OFFSET)
                begin
                    off_reg <= off_reg + OFF_W'(1);
                end
            end
        end
    end

    // queue pointers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            if (accept)
            begin
                wr_ptr_reg <= wr_ptr_reg + PTR_W'(1);
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + PTR_W'(1);
            end
            if (accept && !pop)
            begin
                cnt_reg <= cnt_reg + CNT_W'(1);
            end
            else if (!accept && pop)
            begin
                cnt_reg <= cnt_reg - CNT_W'(1);
            end
        end
    end

    // queue storage
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            mem_reg[wr_ptr_reg] <= rec;
        end
    end

endmodule

`default_nettype wire

### rtl/abdd_back.sv
`default_nettype none

module abdd_back
    import abdd_pkg::*;
#(
    parameter int BINS      = BINS_DEF,
    parameter int KEYPOINTS = KEYPOINTS_DEF
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire cfg_t        cfg,
    input  wire logic        head_valid,
    input  wire rec_t        head,
    output logic             pop,
    output logic             out_valid,
    input  wire logic        out_stall,
    output logic             kind,
    output logic [PIDX_W-1:0]  point_index,
    output logic [COORD_W-1:0] x_pos,
    output logic [COORD_W-1:0] y_pos,
    output logic [SIZE_W-1:0]  box_width,
    output logic [SIZE_W-1:0]  box_height,
    output logic [SCORE_W-1:0] score,
    output logic               run_end
);

    localparam int BIN_W  = $clog2(BINS);
    localparam int KIDX_W = (KEYPOINTS > 1) ? $clog2(KEYPOINTS) : 1;
    localparam int JOB_W  = $clog2(KEYPOINTS + 2);
    localparam int NUM_W  = 2 * BIN_W + EXP_W_W;
    localparam int DEN_W  = BIN_W + EXP_W_W;
    localparam int CX_W   = 2 * ROW_W + 10;

    typedef enum logic [9:0] {
        B_IDLE      = 10'b0000000001,
        B_DFL_ISSUE = 10'b0000000010,
        B_DFL_WAIT  = 10'b0000000100,
        B_DFL_DIV   = 10'b0000001000,
        B_SIG_ISSUE = 10'b0000010000,
        B_SIG_WAIT  = 10'b0000100000,
        B_SIG_DIV   = 10'b0001000000,
        B_GEO_MUL   = 10'b0010000000,
        B_GEO_SCALE = 10'b0100000000,
        B_GEO_EMIT  = 10'b1000000000
    } state_t;

    state_t state_reg, state_next;

    // stores
    logic signed [VAL_W-1:0] bin_mem [BINS];
    logic signed [VAL_W-1:0] off_x_reg [KEYPOINTS];
    logic signed [VAL_W-1:0] off_y_reg [KEYPOINTS];
    logic [15:0]             sd_x_reg [2];
    logic [15:0]             sd_y_reg [2];
    logic signed [VAL_W-1:0] class_reg;
    logic signed [VAL_W-1:0] mx_reg;
    logic [1:0]              side_reg;

    // softmax walk
    logic [BIN_W-1:0] k_reg, recv_reg;
    logic [NUM_W-1:0] num_reg, num_sum;
    logic [DEN_W-1:0] den_reg, den_sum;

    // cell geometry
    logic [ROW_W-1:0]    row_reg, col_reg;
    logic [STRIDE_W-1:0] stride_reg;
    logic [CX_W-1:0]     cx_reg, cy_reg;
    logic [SCORE_W-1:0]  sc_reg;
    logic [JOB_W-1:0]    job_reg;
    logic signed [NET_W-1:0] net_x_reg, net_y_reg;
    logic signed [SC_W-1:0]  scl_x_reg, scl_y_reg;
    logic signed [SC_W-1:0]  xmin_reg, ymin_reg;

    // output slot
    logic               out_valid_reg;
    logic               kind_reg, run_end_reg;
    logic [PIDX_W-1:0]  pidx_reg;
    logic [COORD_W-1:0] x_reg, y_reg;
    logic [SIZE_W-1:0]  w_reg, h_reg;
    logic [SCORE_W-1:0] score_reg;

    // unit handshakes
    logic               exp_in_valid, exp_out_valid;
    logic [EXP_T_W-1:0] exp_t;
    logic [EXP_W_W-1:0] exp_w;
    logic [BIN_W-1:0]   exp_tag;
    logic                 div_start, div_done;
    logic [DIV_DVD_W-1:0] div_dvd;
    logic [DIV_DSR_W-1:0] div_dsr;
    logic [DIV_Q_W-1:0]   div_q;

    // misc combinational
    logic signed [VAL_W:0]   diff;
    logic [VAL_W:0]          abs_class;
    logic [EXP_W_W:0]        sig_d;
    logic [EXP_W_W-1:0]      sc_full;
    logic [SCORE_W-1:0]      sc_c;
    logic                    slot_free, emit, is_box, last_job;
    logic [KIDX_W-1:0]       kidx;
    logic [CX_W-1:0]         cx_c, cy_c;
    logic [23:0]             prod_sx, prod_sy;
    logic signed [NET_W-1:0] base_bx, base_by, base_kx, base_ky, net_x_c, net_y_c;
    logic signed [NET_W-1:0] kx_in, ky_in;
    logic signed [SC_W-1:0]  xmin_c, ymin_c, xmax_c, ymax_c, xlim, ylim;

    abdd_exp #(
        .TAG_W (BIN_W)
    ) u_exp (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (exp_in_valid),
        .in_t      (exp_t),
        .in_tag    (k_reg),
        .out_valid (exp_out_valid),
        .out_w     (exp_w),
        .out_tag   (exp_tag)
    );

    abdd_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_dvd),
        .divisor  (div_dsr),
        .done     (div_done),
        .quotient (div_q)
    );

    assign pop       = (state_reg == B_IDLE) && head_valid;
    assign slot_free = !out_valid_reg || !out_stall;
    assign is_box    = job_reg < JOB_W'(2);
    assign last_job  = job_reg == JOB_W'(KEYPOINTS + 1);
    assign kidx      = is_box ? '0 : KIDX_W'(job_reg - JOB_W'(2));
    assign emit      = (state_reg == B_GEO_EMIT) && (job_reg != '0) && slot_free;

    // exponential and divider operands
    always_comb
    begin
        diff         = (VAL_W+1)'(mx_reg) - (VAL_W+1)'(bin_mem[k_reg]);
        abs_class    = class_reg[VAL_W-1] ? (VAL_W+1)'(-(VAL_W+1)'(class_reg))
                                          : (VAL_W+1)'(class_reg);
        exp_in_valid = (state_reg == B_DFL_ISSUE) || (state_reg == B_SIG_ISSUE);
        exp_t        = (state_reg == B_SIG_ISSUE) ? abs_class[EXP_T_W-1:0]
                                                  : diff[EXP_T_W-1:0];
        num_sum      = num_reg + NUM_W'(exp_tag) * NUM_W'(exp_w);
        den_sum      = den_reg + DEN_W'(exp_w);
        sig_d        = (EXP_W_W+1)'(ONE_Q16) + (EXP_W_W+1)'(exp_w);
        div_start    = exp_out_valid &&
                       (((state_reg == B_DFL_WAIT) && (exp_tag == BIN_W'(BINS - 1))) ||
                        (state_reg == B_SIG_WAIT));
        if (state_reg == B_SIG_WAIT)
        begin
            div_dvd = (DIV_DVD_W'(1) << 32) + DIV_DVD_W'(sig_d >> 1);
            div_dsr = DIV_DSR_W'(sig_d);
        end
        else
        begin
            div_dvd = (DIV_DVD_W'(num_sum) << 11) + DIV_DVD_W'(den_sum >> 1);
            div_dsr = DIV_DSR_W'(den_sum);
        end
    end

    // score from the divider quotient
    always_comb
    begin
        sc_full = class_reg[VAL_W-1] ? EXP_W_W'(ONE_Q16) - div_q : div_q;
        sc_c    = (sc_full > EXP_W_W'(ONE_Q16 - 1)) ? '1 : sc_full[SCORE_W-1:0];
    end

    // geometry operands
    always_comb
    begin
        cx_c    = CX_W'(16'({col_reg, 1'b1}) * 16'(stride_reg)) << 10;
        cy_c    = CX_W'(16'({row_reg, 1'b1}) * 16'(stride_reg)) << 10;
        prod_sx = 24'(sd_x_reg[job_reg[0]]) * 24'(stride_reg);
        prod_sy = 24'(sd_y_reg[job_reg[0]]) * 24'(stride_reg);
        base_bx = job_reg[0] ? NET_W'(cx_reg) + NET_W'(prod_sx)
                             : NET_W'(cx_reg) - NET_W'(prod_sx);
        base_by = job_reg[0] ? NET_W'(cy_reg) + NET_W'(prod_sy)
                             : NET_W'(cy_reg) - NET_W'(prod_sy);
        kx_in   = (NET_W'(off_x_reg[kidx]) <<< 1) + (NET_W'(col_reg) << 10);
        ky_in   = (NET_W'(off_y_reg[kidx]) <<< 1) + (NET_W'(row_reg) << 10);
        base_kx = (kx_in * $signed(NET_W'(stride_reg))) <<< 1;
        base_ky = (ky_in * $signed(NET_W'(stride_reg))) <<< 1;
        net_x_c = (is_box ? base_bx : base_kx) - (NET_W'(cfg.pad_left) << 11);
        net_y_c = (is_box ? base_by : base_ky) - (NET_W'(cfg.pad_top) << 11);
        xlim    = (SC_W'($signed({1'b0, cfg.image_width})) - SC_W'(1)) <<< FRAC_SH;
        ylim    = (SC_W'($signed({1'b0, cfg.image_height})) - SC_W'(1)) <<< FRAC_SH;
        xmin_c  = (scl_x_reg < 0) ? '0 : scl_x_reg;
        ymin_c  = (scl_y_reg < 0) ? '0 : scl_y_reg;
        xmax_c  = (scl_x_reg > xlim) ? xlim : scl_x_reg;
        ymax_c  = (scl_y_reg > ylim) ? ylim : scl_y_reg;
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            B_IDLE:
            begin
                if (head_valid)
                begin
                    if (head.tag == TAG_BIN && head.side_last)
                        state_next = B_DFL_ISSUE;
                    else if (head.cell_end && head.complete)
                        state_next = B_SIG_ISSUE;
                end
            end
            B_DFL_ISSUE:
            begin
                if (k_reg == BIN_W'(BINS - 1))
                    state_next = B_DFL_WAIT;
            end
            B_DFL_WAIT:
            begin
                if (div_start)
                    state_next = B_DFL_DIV;
            end
            B_DFL_DIV:
            begin
                if (div_done)
                    state_next = B_IDLE;
            end
            B_SIG_ISSUE: state_next = B_SIG_WAIT;
            B_SIG_WAIT:
            begin
                if (div_start)
                    state_next = B_SIG_DIV;
            end
            B_SIG_DIV:
            begin
                if (div_done)
                    state_next = (sc_c > cfg.threshold) ? B_GEO_MUL : B_IDLE;
            end
            B_GEO_MUL:   state_next = B_GEO_SCALE;
            B_GEO_SCALE: state_next = B_GEO_EMIT;
            B_GEO_EMIT:
            begin
                if (job_reg == '0)
                    state_next = B_GEO_MUL;
                else if (slot_free)
                    state_next = last_job ? B_IDLE : B_GEO_MUL;
            end
            default: state_next = B_IDLE;
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= B_IDLE;
            out_valid_reg <= 1'b0;
            class_reg     <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (emit)
                out_valid_reg <= 1'b1;
            else if (!out_stall)
                out_valid_reg <= 1'b0;
            if (pop && head.tag == TAG_CLASS)
                class_reg <= head.value;
        end
    end

    // stores and datapath
    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            if (head.tag == TAG_BIN)
            begin
                bin_mem[head.idx[BIN_W-1:0]] <= head.value;
                if (head.idx == '0 || head.value > mx_reg)
                    mx_reg <= head.value;
                side_reg <= head.side;
            end
            if (head.tag == TAG_OFFSET)
            begin
                if (head.idx[0])
                    off_y_reg[head.idx[KIDX_W:1]] <= head.value;
                else
                    off_x_reg[head.idx[KIDX_W:1]] <= head.value;
            end
            if (head.cell_end)
            begin
                row_reg    <= head.row;
                col_reg    <= head.col;
                stride_reg <= head.stride;
            end
            k_reg    <= '0;
            recv_reg <= '0;
            num_reg  <= '0;
            den_reg  <= '0;
            job_reg  <= '0;
        end
        if (state_reg == B_DFL_ISSUE)
            k_reg <= k_reg + BIN_W'(1);
        if (exp_out_valid && (state_reg == B_DFL_ISSUE || state_reg == B_DFL_WAIT))
        begin
            num_reg  <= num_sum;
            den_reg  <= den_sum;
            recv_reg <= recv_reg + BIN_W'(1);
        end
        if (state_reg == B_DFL_DIV && div_done)
        begin
            if (side_reg[0])
                sd_y_reg[side_reg[1]] <= (div_q > DIV_Q_W'(16'hFFFF)) ? '1 : div_q[15:0];
            else
                sd_x_reg[side_reg[1]] <= (div_q > DIV_Q_W'(16'hFFFF)) ? '1 : div_q[15:0];
        end
        if (state_reg == B_SIG_WAIT)
        begin
            cx_reg <= cx_c;
            cy_reg <= cy_c;
        end
        if (state_reg == B_SIG_DIV && div_done)
            sc_reg <= sc_c;
        if (state_reg == B_GEO_MUL)
        begin
            net_x_reg <= net_x_c;
            net_y_reg <= net_y_c;
        end
        if (state_reg == B_GEO_SCALE)
        begin
            scl_x_reg <= SC_W'(net_x_reg) * $signed(SC_W'(cfg.scale_x));
            scl_y_reg <= SC_W'(net_y_reg) * $signed(SC_W'(cfg.scale_y));
        end
        if (state_reg == B_GEO_EMIT && job_reg == '0)
        begin
            xmin_reg <= xmin_c;
            ymin_reg <= ymin_c;
            job_reg  <= job_reg + JOB_W'(1);
        end
        if (emit)
        begin
            job_reg   <= job_reg + JOB_W'(1);
            score_reg <= sc_reg;
            if (is_box)
            begin
                kind_reg    <= 1'b0;
                pidx_reg    <= '0;
                x_reg       <= sat_coord(DIFF_W'(xmin_reg));
                y_reg       <= sat_coord(DIFF_W'(ymin_reg));
                w_reg       <= sat_size(DIFF_W'(xmax_c) - DIFF_W'(xmin_reg));
                h_reg       <= sat_size(DIFF_W'(ymax_c) - DIFF_W'(ymin_reg));
                run_end_reg <= 1'b0;
            end
            else
            begin
                kind_reg    <= 1'b1;
                pidx_reg    <= PIDX_W'(kidx);
                x_reg       <= sat_coord(DIFF_W'(scl_x_reg));
                y_reg       <= sat_coord(DIFF_W'(scl_y_reg));
                w_reg       <= '0;
                h_reg       <= '0;
                run_end_reg <= last_job;
            end
        end
    end

    assign out_valid   = out_valid_reg;
    assign kind        = kind_reg;
    assign point_index = pidx_reg;
    assign x_pos       = x_reg;
    assign y_pos       = y_reg;
    assign box_width   = w_reg;
    assign box_height  = h_reg;
    assign score       = score_reg;
    assign run_end     = run_end_reg;

endmodule

`default_nettype wire

### rtl/anchor_box_dfl_decode.sv
// Box and keypoint decoder for one anchor-free detector grid cell at a time.
// Input channel (in_valid / in_stall): one value per request, in cell order:
// class logit, 4 x BINS distance logits, 2 x KEYPOINTS offsets; cell_end
// marks the last value, and row, column and stride are taken from it.
// Output channel (out_valid / out_stall): a passing cell gives one box result
// and then KEYPOINTS keypoint results, run_end on the last one.
// Configuration (cfg_valid / cfg_ready / cfg_index / cfg_data): always ready;
// the user must write it only while the block is idle (not enforced).
// The front takes one value per cycle, while in_stall is low, into a
// two-entry queue. The back pops a plain value and stores it; on the last
// bin of a side it runs the exponential pipeline, 7 deep, then the
// divider, and on a complete cell end it computes the score the same way,
// then, if the score passes, the geometry steps for each result. The
// softmax walk and the shared divider set the pace.
// Reset clears position, queue and output slot and loads the register
// defaults. While the receiver stalls, the output slot holds its result,
// the back waits and the queue fills, then in_stall rises.
`default_nettype none

module anchor_box_dfl_decode
    import abdd_pkg::*;
#(
    parameter int BINS      = BINS_DEF,
    parameter int KEYPOINTS = KEYPOINTS_DEF
)
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  in_valid,
    output logic                       in_stall,
    input  wire logic [ROW_W-1:0]      cell_row,
    input  wire logic [ROW_W-1:0]      cell_col,
    input  wire logic [STRIDE_W-1:0]   stride,
    input  wire logic [VAL_W-1:0]      value,
    input  wire logic                  cell_end,
    output logic                       out_valid,
    input  wire logic                  out_stall,
    output logic                       kind,
    output logic [PIDX_W-1:0]          point_index,
    output logic [COORD_W-1:0]         x_pos,
    output logic [COORD_W-1:0]         y_pos,
    output logic [SIZE_W-1:0]          box_width,
    output logic [SIZE_W-1:0]          box_height,
    output logic [SCORE_W-1:0]         score,
    output logic                       run_end,
    input  wire logic                  cfg_valid,
    output logic                       cfg_ready,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_data
);

    cfg_t cfg_reg;
    logic head_valid, pop;
    rec_t head;

    assign cfg_ready = 1'b1;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.threshold    <= SCORE_W'(29491);
            cfg_reg.pad_left     <= '0;
            cfg_reg.pad_top      <= '0;
            cfg_reg.scale_x      <= SCALE_W'(4096);
            cfg_reg.scale_y      <= SCALE_W'(4096);
            cfg_reg.image_width  <= IMG_W'(640);
            cfg_reg.image_height <= IMG_W'(640);
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_addr_t'(cfg_index))
                CFG_THRESHOLD:  cfg_reg.threshold    <= cfg_data;
                CFG_PAD_LEFT:   cfg_reg.pad_left     <= cfg_data[PAD_W-1:0];
                CFG_PAD_TOP:    cfg_reg.pad_top      <= cfg_data[PAD_W-1:0];
                CFG_SCALE_X:    cfg_reg.scale_x      <= cfg_data;
                CFG_SCALE_Y:    cfg_reg.scale_y      <= cfg_data;
                CFG_IMG_WIDTH:  cfg_reg.image_width  <= cfg_data[IMG_W-1:0];
                CFG_IMG_HEIGHT: cfg_reg.image_height <= cfg_data[IMG_W-1:0];
                default: ;
            endcase
        end
    end

    abdd_front #(
        .BINS      (BINS),
        .KEYPOINTS (KEYPOINTS)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .cell_row   (cell_row),
        .cell_col   (cell_col),
        .stride     (stride),
        .value      (value),
        .cell_end   (cell_end),
        .pop        (pop),
        .head_valid (head_valid),
        .head       (head)
    );

    abdd_back #(
        .BINS      (BINS),
        .KEYPOINTS (KEYPOINTS)
    ) u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg         (cfg_reg),
        .head_valid  (head_valid),
        .head        (head),
        .pop         (pop),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .kind        (kind),
        .point_index (point_index),
        .x_pos       (x_pos),
        .y_pos       (y_pos),
        .box_width   (box_width),
        .box_height  (box_height),
        .score       (score),
        .run_end     (run_end)
    );

endmodule

`default_nettype wire

### verif/box_result_checker.sv
`default_nettype none

module box_result_checker
    import abdd_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  in_valid,
    input  wire logic                  in_stall,
    input  wire logic [ROW_W-1:0]      cell_row,
    input  wire logic [ROW_W-1:0]      cell_col,
    input  wire logic [STRIDE_W-1:0]   stride,
    input  wire logic [VAL_W-1:0]      value,
    input  wire logic                  cell_end,
    input  wire logic                  out_valid,
    input  wire logic                  out_stall,
    input  wire logic                  kind,
    input  wire logic [PIDX_W-1:0]     point_index,
    input  wire logic [COORD_W-1:0]    x_pos,
    input  wire logic [COORD_W-1:0]    y_pos,
    input  wire logic [SIZE_W-1:0]     box_width,
    input  wire logic [SIZE_W-1:0]     box_height,
    input  wire logic [SCORE_W-1:0]    score,
    input  wire logic                  run_end,
    input  wire logic                  cfg_valid,
    input  wire logic                  cfg_ready,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_data,
    output int                         fail_count,
    output int                         pending,
    output int                         results_seen
);

    localparam int NBINS    = BINS_DEF;
    localparam int NPOINTS  = KEYPOINTS_DEF;
    localparam int CELL_LEN = 1 + SIDES * NBINS + 2 * NPOINTS;

    typedef struct packed {
        logic                kind;
        logic [PIDX_W-1:0]   pidx;
        logic [COORD_W-1:0]  x;
        logic [COORD_W-1:0]  y;
        logic [SIZE_W-1:0]   w;
        logic [SIZE_W-1:0]   h;
        logic [SCORE_W-1:0]  score;
        logic                last;
    } detection_t;

    detection_t expected_results[$];

    // shadow registers
    logic [SCORE_W-1:0] thr_q;
    logic [PAD_W-1:0]   padl_q, padt_q;
    logic [SCALE_W-1:0] scx_q, scy_q;
    logic [IMG_W-1:0]   imw_q, imh_q;

    // shadow cell state
    int                      cell_pos;
    logic signed [VAL_W-1:0] class_q;
    logic signed [VAL_W-1:0] bins_q [NBINS];
    logic [15:0]             dist_q [SIDES];
    logic signed [VAL_W-1:0] offs_q [2*NPOINTS];

    localparam longint unsigned QPOW [4] = '{65536, 55109, 46341, 38968};

    // e^-t with t in q.10, result q0.16
    function automatic longint unsigned exp_q16(input longint unsigned t);
        longint unsigned u, n, f, a, a2, a3, p, m;
        u = (t * 94548 + 512) >> 10;
        n = u >> 16;
        f = u & 64'hFFFF;
        if (n > 16)
            return 0;
        a  = ((f & 64'h3FFF) * 45426 + 32768) >> 16;
        a2 = (a * a + 32768) >> 16;
        a3 = (a2 * a + 32768) >> 16;
        p  = (65536 - a) + (a2 >> 1) - a3 / 6;
        m  = (p * QPOW[f >> 14] + 32768) >> 16;
        if (n > 0)
            m = (m + (64'd1 << (n - 1))) >> n;
        return m;
    endfunction

    function automatic longint unsigned sigmoid_q16(input longint x);
        longint unsigned d, s;
        d = 65536 + exp_q16((x < 0) ? -x : x);
        s = ((64'd1 << 32) + d / 2) / d;
        if (x < 0)
            s = 65536 - s;
        return (s > 65535) ? 65535 : s;
    endfunction

    // softmax expectation of the bin index, q5.11
    function automatic logic [15:0] side_expectation();
        longint mx;
        longint unsigned num, den, w, r;
        mx = bins_q[0];
        num = 0;
        den = 0;
        for (int k = 1; k < NBINS; k++)
            if (bins_q[k] > mx)
                mx = bins_q[k];
        for (int k = 0; k < NBINS; k++)
        begin
            w = exp_q16(longint'(mx - longint'(bins_q[k])));
            num += longint'(k) * w;
            den += w;
        end
        r = ((num << 11) + den / 2) / den;
        return (r > 65535) ? 16'hFFFF : r[15:0];
    endfunction

    function automatic longint trunc_sh(input longint v, input int s);
        if (v < 0)
            return -((-v) >> s);
        return v >> s;
    endfunction

    function automatic longint clampl(input longint v, input longint lo, input longint hi);
        return (v < lo) ? lo : ((v > hi) ? hi : v);
    endfunction

    task automatic decode_value(input logic [7:0] r8, input logic [7:0] c8,
                                input logic [6:0] s7, input logic [15:0] v16,
                                input logic e);
        bit complete;
        int i;
        longint row, col, s, sc, cx, cy, xmin, ymin, xmax, ymax, xv, yv, ox, oy;
        detection_t d;
        complete = 0;
        row = r8;
        col = c8;
        s = s7;
        if (cell_pos < CELL_LEN)
        begin
            if (cell_pos == 0)
                class_q = v16;
            else if (cell_pos <= SIDES * NBINS)
            begin
                i = cell_pos - 1;
                bins_q[i % NBINS] = v16;
                if (i % NBINS == NBINS - 1)
                    dist_q[i / NBINS] = side_expectation();
            end
            else
                offs_q[(cell_pos - 1 - SIDES * NBINS) % (2 * NPOINTS)] = v16;
            complete = (cell_pos == CELL_LEN - 1);
            cell_pos++;
        end
        if (!e)
            return;
        cell_pos = 0;
        if (!complete)
            return;
        sc = sigmoid_q16(class_q);
        if (sc <= thr_q)
            return;

        // box in q.11 network pixels, scaled to q.23
        cx = ((2 * col + 1) * s) <<< 10;
        cy = ((2 * row + 1) * s) <<< 10;
        xmin = (cx - longint'(dist_q[0]) * s - (longint'(padl_q) <<< 11)) * longint'(scx_q);
        ymin = (cy - longint'(dist_q[1]) * s - (longint'(padt_q) <<< 11)) * longint'(scy_q);
        xmax = (cx + longint'(dist_q[2]) * s - (longint'(padl_q) <<< 11)) * longint'(scx_q);
        ymax = (cy + longint'(dist_q[3]) * s - (longint'(padt_q) <<< 11)) * longint'(scy_q);
        if (xmin < 0) xmin = 0;
        if (ymin < 0) ymin = 0;
        if (xmax > (longint'(imw_q) - 1) * 8388608) xmax = (longint'(imw_q) - 1) * 8388608;
        if (ymax > (longint'(imh_q) - 1) * 8388608) ymax = (longint'(imh_q) - 1) * 8388608;
        d.kind  = 1'b0;
        d.pidx  = '0;
        d.x     = COORD_W'(clampl(trunc_sh(xmin, 23), -8192, 8191));
        d.y     = COORD_W'(clampl(trunc_sh(ymin, 23), -8192, 8191));
        d.w     = SIZE_W'(clampl(trunc_sh(xmax - xmin, 23), 0, 8191));
        d.h     = SIZE_W'(clampl(trunc_sh(ymax - ymin, 23), 0, 8191));
        d.score = sc[15:0];
        d.last  = 1'b0;
        expected_results.push_back(d);

        // keypoints in q.10 network pixels, scaled to q.22
        for (int k = 0; k < NPOINTS; k++)
        begin
            ox = offs_q[2*k];
            oy = offs_q[2*k+1];
            xv = ((2 * ox + (col <<< 10)) * s - (longint'(padl_q) <<< 10)) * longint'(scx_q);
            yv = ((2 * oy + (row <<< 10)) * s - (longint'(padt_q) <<< 10)) * longint'(scy_q);
            d.kind = 1'b1;
            d.pidx = PIDX_W'(k);
            d.x    = COORD_W'(clampl(trunc_sh(xv, 22), -8192, 8191));
            d.y    = COORD_W'(clampl(trunc_sh(yv, 22), -8192, 8191));
            d.w    = '0;
            d.h    = '0;
            d.last = (k == NPOINTS - 1);
            expected_results.push_back(d);
        end
    endtask

    function automatic bit field_ok(input string name, input longint e, input longint a);
        if (e != a)
        begin
            $error("%s mismatch: expected %0d, got %0d", name, e, a);
            return 0;
        end
        return 1;
    endfunction

    assign pending = expected_results.size();

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            thr_q    <= 16'd29491;
            padl_q   <= '0;
            padt_q   <= '0;
            scx_q    <= 16'd4096;
            scy_q    <= 16'd4096;
            imw_q    <= 14'd640;
            imh_q    <= 14'd640;
            cell_pos  = 0;
            class_q   = '0;
            expected_results.delete();
        end
        else
        begin
            // register writes
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_addr_t'(cfg_index))
                    CFG_THRESHOLD:  thr_q  <= cfg_data;
                    CFG_PAD_LEFT:   padl_q <= cfg_data[PAD_W-1:0];
                    CFG_PAD_TOP:    padt_q <= cfg_data[PAD_W-1:0];
                    CFG_SCALE_X:    scx_q  <= cfg_data;
                    CFG_SCALE_Y:    scy_q  <= cfg_data;
                    CFG_IMG_WIDTH:  imw_q  <= cfg_data[IMG_W-1:0];
                    CFG_IMG_HEIGHT: imh_q  <= cfg_data[IMG_W-1:0];
                    default: ;
                endcase
            end

            // accepted input request
            if (in_valid && !in_stall)
                decode_value(cell_row, cell_col, stride, value, cell_end);

            // accepted result
            if (out_valid && !out_stall)
            begin
                results_seen <= results_seen + 1;
                if (expected_results.size() == 0)
                begin
                    $error("unexpected result: kind %0d x %0d y %0d", kind, x_pos, y_pos);
                    fail_count <= fail_count + 1;
                end
                else
                begin
                    detection_t d;
                    bit ok;
                    d = expected_results.pop_front();
                    ok = 1;
                    ok &= field_ok("kind", d.kind, kind);
                    ok &= field_ok("point_index", d.pidx, point_index);
                    ok &= field_ok("x_pos", d.x, x_pos);
                    ok &= field_ok("y_pos", d.y, y_pos);
                    ok &= field_ok("box_width", d.w, box_width);
                    ok &= field_ok("box_height", d.h, box_height);
                    ok &= field_ok("score", d.score, score);
                    ok &= field_ok("run_end", d.last, run_end);
                    if (!ok)
                        fail_count <= fail_count + 1;
                end
            end
        end
    end

    initial
    begin
        fail_count   = 0;
        results_seen = 0;
    end

endmodule

`default_nettype wire

### verif/tb_anchor_box_dfl_decode.sv
`default_nettype none

module tb_anchor_box_dfl_decode;
    import abdd_pkg::*;

    localparam int CELL_LEN   = 1 + SIDES * BINS_DEF + 2 * KEYPOINTS_DEF;
    localparam int LIMIT      = 1000000;
    localparam int DRAIN      = 400;
    localparam int HOLD_LEN   = 600;

    logic                  clk;
    logic                  rst_n;
    logic                  in_valid;
    logic                  in_stall;
    logic [ROW_W-1:0]      cell_row;
    logic [ROW_W-1:0]      cell_col;
    logic [STRIDE_W-1:0]   stride;
    logic [VAL_W-1:0]      value;
    logic                  cell_end;
    logic                  out_valid;
    logic                  out_stall;
    logic                  kind;
    logic [PIDX_W-1:0]     point_index;
    logic [COORD_W-1:0]    x_pos;
    logic [COORD_W-1:0]    y_pos;
    logic [SIZE_W-1:0]     box_width;
    logic [SIZE_W-1:0]     box_height;
    logic [SCORE_W-1:0]    score;
    logic                  run_end;
    logic                  cfg_valid;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    int fail_count;
    int pending;
    int results_seen;
    int cycles;
    int items_sent;
    int hold_req;
    int hold_seen;
    int hold_left;
    int seg_left;
    logic seg_val;

    anchor_box_dfl_decode u_top (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_stall(in_stall),
        .cell_row(cell_row), .cell_col(cell_col), .stride(stride),
        .value(value), .cell_end(cell_end),
        .out_valid(out_valid), .out_stall(out_stall),
        .kind(kind), .point_index(point_index), .x_pos(x_pos), .y_pos(y_pos),
        .box_width(box_width), .box_height(box_height), .score(score),
        .run_end(run_end),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    box_result_checker u_checker (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_stall(in_stall),
        .cell_row(cell_row), .cell_col(cell_col), .stride(stride),
        .value(value), .cell_end(cell_end),
        .out_valid(out_valid), .out_stall(out_stall),
        .kind(kind), .point_index(point_index), .x_pos(x_pos), .y_pos(y_pos),
        .box_width(box_width), .box_height(box_height), .score(score),
        .run_end(run_end),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data),
        .fail_count(fail_count), .pending(pending), .results_seen(results_seen)
    );

    // clock
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // run limit
    initial cycles = 0;
    always @(posedge clk)
    begin
        cycles++;
        if (cycles > LIMIT)
        begin
            $display("TB_ERROR");
            $finish;
        end
    end

    // receiver stall pattern, with a long hold-off on request
    always @(posedge clk)
    begin
        int r;
        if (hold_req != hold_seen)
        begin
            hold_seen = hold_req;
            hold_left = HOLD_LEN;
        end
        if (hold_left > 0)
        begin
            hold_left--;
            out_stall <= 1'b1;
        end
        else if (seg_left > 0)
        begin
            seg_left--;
            out_stall <= seg_val;
        end
        else
        begin
            r = $urandom_range(0, 99);
            if (r < 50)
            begin
                seg_val = 1'b0;
                seg_left = $urandom_range(0, 4);
            end
            else if (r < 85)
            begin
                seg_val = 1'b1;
                seg_left = $urandom_range(0, 3);
            end
            else if (r < 93)
            begin
                seg_val = 1'b0;
                seg_left = $urandom_range(50, 200);
            end
            else
            begin
                seg_val = 1'b1;
                seg_left = $urandom_range(15, 60);
            end
            out_stall <= seg_val;
        end
    end

    // one input request, then a random gap
    task automatic send_item(input logic [7:0] r, input logic [7:0] c, input logic [6:0] s,
                             input logic [15:0] v, input logic e);
        int g;
        int gap;
        cell_row <= r;
        cell_col <= c;
        stride   <= s;
        value    <= v;
        cell_end <= e;
        in_valid <= 1'b1;
        do
            @(posedge clk);
        while (in_stall);
        items_sent++;
        g = $urandom_range(0, 99);
        gap = (g < 60) ? 0 : ((g < 92) ? $urandom_range(1, 3) : $urandom_range(10, 40));
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    // content styles: 0 random, 1 high extremes, 2 low extremes, 3 all zero
    task automatic send_cell(input int nvals, input int style, input logic [7:0] r,
                             input logic [7:0] c, input logic [6:0] s);
        bit narrow;
        bit last;
        int v;
        narrow = $urandom_range(0, 1);
        for (int p = 0; p < nvals; p++)
        begin
            last = (p == nvals - 1);
            case (style)
                1: v = (p == 0) ? 32767 :
                       (p <= SIDES * BINS_DEF) ? (((p - 1) % BINS_DEF == 0) ? 32767 : -32768) :
                       ((p % 2 == 0) ? 32767 : -32768);
                2: v = -32768;
                3: v = 0;
                default:
                begin
                    if (p == 0)
                        v = ($urandom_range(0, 3) == 0) ? int'($urandom_range(0, 65535))
                                                        : int'($urandom_range(0, 8000));
                    else if (narrow)
                        v = int'($urandom_range(0, 6000)) - 3000;
                    else
                        v = int'($urandom_range(0, 65535));
                end
            endcase
            if (last)
                send_item(r, c, s, v[15:0], 1'b1);
            else
                send_item($urandom_range(0, 255), $urandom_range(0, 255),
                          $urandom_range(0, 127), v[15:0], 1'b0);
        end
    endtask

    task automatic send_random_cell();
        int m;
        int n;
        m = $urandom_range(0, 99);
        if (m < 75)
            n = CELL_LEN;
        else if (m < 87)
            n = $urandom_range(1, CELL_LEN - 1);
        else
            n = $urandom_range(CELL_LEN + 1, CELL_LEN + 15);
        send_cell(n, 0, $urandom_range(0, 255), $urandom_range(0, 255),
                  $urandom_range(1, 64));
    endtask

    // wait until every expected result is out, then let the back drain
    task automatic wait_idle();
        in_valid <= 1'b0;
        while (pending != 0)
            @(posedge clk);
        repeat (DRAIN) @(posedge clk);
    endtask

    task automatic write_reg(input cfg_addr_t idx, input logic [15:0] d);
        cfg_index <= idx;
        cfg_data  <= d;
        cfg_valid <= 1'b1;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
    endtask

    task automatic write_all(input logic [15:0] thr, input logic [15:0] pl,
                             input logic [15:0] pt, input logic [15:0] sx,
                             input logic [15:0] sy, input logic [15:0] iw,
                             input logic [15:0] ih);
        write_reg(CFG_THRESHOLD, thr);
        write_reg(CFG_PAD_LEFT, pl);
        write_reg(CFG_PAD_TOP, pt);
        write_reg(CFG_SCALE_X, sx);
        write_reg(CFG_SCALE_Y, sy);
        write_reg(CFG_IMG_WIDTH, iw);
        write_reg(CFG_IMG_HEIGHT, ih);
    endtask

    task automatic random_phase(input int quota);
        int start;
        start = items_sent;
        while (items_sent - start < quota)
            send_random_cell();
    endtask

    initial
    begin
        rst_n      = 1'b0;
        in_valid   = 1'b0;
        cell_row   = '0;
        cell_col   = '0;
        stride     = '0;
        value      = '0;
        cell_end   = 1'b0;
        out_stall  = 1'b0;
        cfg_valid  = 1'b0;
        cfg_index  = CFG_THRESHOLD;
        cfg_data   = '0;
        items_sent = 0;
        hold_req   = 0;
        hold_seen  = 0;
        hold_left  = 0;
        seg_left   = 0;
        seg_val    = 1'b0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: lone end, short, extremes, low score, stride zero, uniform, long
        send_item(8'd0, 8'd0, 7'd1, 16'h7FFF, 1'b1);
        send_cell(10, 0, 8'd3, 8'd4, 7'd8);
        send_cell(CELL_LEN, 1, 8'd255, 8'd255, 7'd64);
        send_cell(CELL_LEN, 2, 8'd0, 8'd0, 7'd1);
        send_cell(CELL_LEN, 1, 8'd10, 8'd20, 7'd0);
        send_cell(CELL_LEN, 3, 8'd0, 8'd0, 7'd1);
        send_cell(CELL_LEN + 5, 0, 8'd1, 8'd1, 7'd32);
        wait_idle();

        // wide open: low threshold, largest scale, large image, receiver holds off
        write_all(16'd0, 16'd0, 16'd0, 16'hFFFF, 16'hFFFF, 16'd8192, 16'd8192);
        hold_req++;
        random_phase(90);
        wait_idle();

        // closed: top threshold, largest padding, zero scale, one pixel image
        write_all(16'hFFFF, 16'd4095, 16'd4095, 16'd0, 16'd0, 16'd1, 16'd1);
        random_phase(40);
        wait_idle();

        // tiny image with passing score gives inverted boxes
        write_all(16'd0, 16'd100, 16'd100, 16'd4096, 16'd4096, 16'd1, 16'd1);
        send_cell(CELL_LEN, 3, 8'd50, 8'd50, 7'd16);
        random_phase(40);
        wait_idle();

        // random settings, until enough results have come
        for (int ph = 0; ph < 3; ph++)
        begin
            write_all($urandom_range(0, 40000), $urandom_range(0, 4095),
                      $urandom_range(0, 4095), $urandom_range(0, 65535),
                      $urandom_range(0, 65535), $urandom_range(1, 8192),
                      $urandom_range(1, 8192));
            random_phase(80);
            if (ph == 2)
                for (int k = 0; k < 40 && results_seen < 60; k++)
                    send_cell(CELL_LEN, 0, $urandom_range(0, 255), $urandom_range(0, 255),
                              $urandom_range(1, 64));
            wait_idle();
        end

        if (fail_count == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule

`default_nettype wire
